[src/csp_pkg.sv]
`default_nettype none
package csp_pkg;

   localparam int StackDepth = 256;
   localparam int Buckets    = 256;
   localparam int Ways       = 4;
   localparam int DepthW     = $clog2(StackDepth + 1);
   localparam int SlotW      = $clog2(StackDepth);
   localparam int BucketW    = (Buckets > 1) ? $clog2(Buckets) : 1;
   localparam int WayW       = (Ways > 1) ? $clog2(Ways) : 1;
   localparam logic [31:0] CallLen = 32'd5;
   localparam logic [31:0] Sat32   = 32'hffffffff;

   localparam logic OP_ENTER = 1'b0;
   localparam logic OP_EXIT  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DISABLED  = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_UNDERFLOW = 3'd3,
      ST_FULL      = 3'd4,
      ST_UNTRACKED = 3'd5
   } status_type;

   typedef struct packed {
      logic        opcode;
      logic [31:0] call_site;
      logic [31:0] return_addr;
      logic [63:0] timestamp;
   } req_type;

   typedef struct packed {
      logic        event_kind;
      logic        redirect;
      logic [31:0] resume_addr;
      logic [31:0] func_addr;
      logic [31:0] call_count;
      logic [31:0] duration;
      logic [31:0] time_min;
      logic [31:0] time_max;
      logic [31:0] time_total;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [31:0] calls;
      logic [31:0] tmin;
      logic [31:0] tmax;
      logic [31:0] total;
   } entry_type;

   typedef enum logic [2:0] {
      FSM_CLEAR  = 3'd0,
      FSM_IDLE   = 3'd1,
      FSM_EXEC   = 3'd2,
      FSM_LOOKUP = 3'd3,
      FSM_OUT    = 3'd4
   } fsm_type;

endpackage
`default_nettype wire

[src/csp_stack.sv]
`default_nettype none
module csp_stack
   import csp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [SlotW-1:0]   wr_addr,
   input  wire logic [127:0]       wr_data,
   input  wire logic [SlotW-1:0]   rd_addr,
   output logic      [127:0]       rd_data
);
   // frame = func, return, enter time
   logic [127:0] mem [StackDepth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[src/csp_table.sv]
`default_nettype none
module csp_table
   import csp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [BucketW-1:0]        wr_addr,
   input  wire entry_type [Ways-1:0]      wr_data,
   input  wire logic [BucketW-1:0]        rd_addr,
   output entry_type [Ways-1:0]           rd_data
);
   // one row holds all ways of a bucket
   entry_type [Ways-1:0] mem [Buckets];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[src/call_stack_profiler.sv]
`default_nettype none
// Call stack profiler.
// The req_ channel takes enter/exit transactions with a 64-bit timestamp;
// the rsp_ channel returns one result transaction for each of them.
// csr_wr_en/csr_wr_data write the enable bit, which the user must write
// only while the block is idle; the block itself does not enforce this.
// An enter transaction reads its bucket row at acceptance, then decides
// and writes back in the next cycle; its result is registered there and
// valid in FSM_OUT. An exit first reads the stack frame, then the bucket
// row of the popped function, then writes back, so its result is valid
// in FSM_OUT after FSM_EXEC and FSM_LOOKUP. A new transaction is taken
// only from idle, after the prior result is delivered, so none is taken
// while one is in flight or while rsp_stall holds the result.
// While rsp_stall is high the result holds and req_stall stays high.
// Reset clears the stack depth and the enable bit, then runs a clearing
// pass over all 256 bucket rows (one bucket row per cycle) with req_stall high.
// Stack frames are undefined until written and are only read behind the
// depth counter; table entries carry their own valid bit.
module call_stack_profiler
   import csp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_wr_en,
   input  wire logic    csr_wr_data
);
   fsm_type state_ff, state_in;
   logic enable_ff;
   logic [DepthW-1:0] depth_ff, depth_in;
   logic [BucketW-1:0] clear_ff, clear_in;
   req_type req_ff;
   rsp_type rsp_ff, rsp_in;
   logic [127:0] frame_ff;

   logic stk_we, tab_we;
   logic [SlotW-1:0] stk_waddr, stk_raddr;
   logic [127:0] stk_wdata, stk_rdata;
   logic [BucketW-1:0] tab_raddr, tab_waddr;
   entry_type [Ways-1:0] tab_wdata, tab_rdata;

   logic [31:0] req_func, cmp_func;
   logic [63:0] diff;
   logic [31:0] dur;
   logic [32:0] sum;
   logic hit, free_found;
   logic [WayW-1:0] hit_w, free_w;
   entry_type e;

   wire accept = req_valid && !req_stall;
   wire [31:0] enter_func = req_data.call_site - CallLen;

   csp_stack u_stack (.clock, .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rdata));
   csp_table u_table (.clock, .wr_en(tab_we), .wr_addr(tab_waddr), .wr_data(tab_wdata),
      .rd_addr(tab_raddr), .rd_data(tab_rdata));

   // read the top frame and the enter bucket at acceptance, the exit bucket from the frame
   always_comb begin
      stk_raddr = SlotW'(depth_ff - DepthW'(1));
      if (state_ff == FSM_EXEC) begin
         tab_raddr = BucketW'(stk_rdata[127:96] % Buckets);
      end else begin
         tab_raddr = BucketW'(enter_func % Buckets);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_CLEAR;
         enable_ff <= 1'b0;
         depth_ff  <= '0;
         clear_ff  <= '0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         clear_ff <= clear_in;
         if (csr_wr_en) enable_ff <= csr_wr_data;
      end
      if (accept) req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   // hold the popped frame for the lookup cycle
   always_ff @(posedge clock) begin
      if (state_ff == FSM_EXEC) begin
         frame_ff <= stk_rdata;
      end
   end

   // next state, memory writes and result
   always_comb begin
      state_in  = state_ff;
      depth_in  = depth_ff;
      clear_in  = clear_ff;
      rsp_in    = rsp_ff;
      req_func  = req_ff.call_site - CallLen;
      cmp_func  = (state_ff == FSM_EXEC) ? req_func : frame_ff[127:96];
      stk_we    = 1'b0;
      stk_waddr = SlotW'(depth_ff);
      stk_wdata = {req_func, req_ff.return_addr, req_ff.timestamp};
      tab_we    = 1'b0;
      tab_waddr = BucketW'(cmp_func % Buckets);
      tab_wdata = tab_rdata;
      hit = 1'b0; free_found = 1'b0; hit_w = '0; free_w = '0;
      diff = req_ff.timestamp - frame_ff[63:0];
      dur  = (diff > {32'd0, Sat32}) ? Sat32 : diff[31:0];
      e    = '0;
      sum  = '0;
      for (int w = Ways - 1; w >= 0; w--) begin
         if (tab_rdata[w].valid && tab_rdata[w].key == cmp_func) begin
            hit = 1'b1; hit_w = WayW'(w);
         end
         if (!tab_rdata[w].valid) begin
            free_found = 1'b1; free_w = WayW'(w);
         end
      end
      unique case (state_ff)
         FSM_CLEAR: begin
            // wipe one bucket row per cycle
            tab_we    = 1'b1;
            tab_waddr = clear_ff;
            tab_wdata = '0;
            clear_in  = clear_ff + BucketW'(1);
            if (clear_ff == BucketW'(Buckets - 1)) state_in = FSM_IDLE;
         end
         FSM_IDLE: begin
            if (accept) state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            if (req_ff.opcode == OP_ENTER) begin
               // enter decides with the bucket row read at acceptance
               rsp_in = '0;
               rsp_in.event_kind  = OP_ENTER;
               rsp_in.resume_addr = req_ff.return_addr;
               rsp_in.func_addr   = req_func;
               state_in = FSM_OUT;
               if (!enable_ff) begin
                  rsp_in.status = ST_DISABLED;
               end else if (depth_ff >= DepthW'(StackDepth)) begin
                  rsp_in.status = ST_OVERFLOW;
               end else begin
                  stk_we = 1'b1;
                  depth_in = depth_ff + DepthW'(1);
                  rsp_in.redirect = 1'b1;
                  if (hit || free_found) begin
                     if (hit) begin
                        e = tab_rdata[hit_w];
                     end else begin
                        e = '{valid: 1'b1, key: req_func, calls: '0, tmin: Sat32,
                              tmax: '0, total: '0};
                     end
                     if (e.calls != Sat32) e.calls = e.calls + 32'd1;
                     tab_wdata[hit ? hit_w : free_w] = e;
                     tab_we = 1'b1;
                     rsp_in.call_count = e.calls;
                     rsp_in.time_min   = e.tmin;
                     rsp_in.time_max   = e.tmax;
                     rsp_in.time_total = e.total;
                     rsp_in.status     = ST_OK;
                  end else begin
                     rsp_in.status = ST_FULL;
                  end
               end
            end else if (depth_ff == '0) begin
               rsp_in = '0;
               rsp_in.event_kind = OP_EXIT;
               rsp_in.status = ST_UNDERFLOW;
               state_in = FSM_OUT;
            end else begin
               // pop now, look up the bucket of the popped function next
               depth_in = depth_ff - DepthW'(1);
               state_in = FSM_LOOKUP;
            end
         end
         FSM_LOOKUP: begin
            // exit with frame and bucket row in hand
            rsp_in = '0;
            rsp_in.event_kind  = OP_EXIT;
            rsp_in.resume_addr = frame_ff[95:64];
            rsp_in.func_addr   = frame_ff[127:96];
            rsp_in.duration    = dur;
            state_in = FSM_OUT;
            if (hit) begin
               e = tab_rdata[hit_w];
               if (e.tmin > dur) e.tmin = dur;
               if (e.tmax < dur) e.tmax = dur;
               sum = {1'b0, e.total} + {1'b0, dur};
               e.total = sum[32] ? Sat32 : sum[31:0];
               tab_wdata[hit_w] = e;
               tab_we = 1'b1;
               rsp_in.call_count = e.calls;
               rsp_in.time_min   = e.tmin;
               rsp_in.time_max   = e.tmax;
               rsp_in.time_total = e.total;
               rsp_in.status     = ST_OK;
            end else begin
               rsp_in.status = ST_UNTRACKED;
            end
         end
         FSM_OUT: begin
            if (!rsp_stall) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   assign req_stall = (state_ff != FSM_IDLE);
   assign rsp_valid = (state_ff == FSM_OUT);
   assign rsp_data  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");
   assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DepthW'(StackDepth))
      else $error("stack depth beyond capacity");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_UNDERFLOW) |-> rsp_data.resume_addr == '0)
      else $error("underflow result not cleared");
endmodule
`default_nettype wire

[bench/call_stack_profiler_checker.sv]
`timescale 1ns / 1ps
module call_stack_profiler_checker
   import csp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   input  wire logic    csr_wr_en,
   input  wire logic    csr_wr_data,
   output int           fail_count,
   output int           pending_count,
   output int           result_count
);

   // profiler state as the block should hold it
   logic        prof_enable;
   int unsigned frame_depth;
   logic [31:0] frame_func [StackDepth];
   logic [31:0] frame_ret [StackDepth];
   logic [63:0] frame_time [StackDepth];
   logic        slot_used [Buckets * Ways];
   entry_type   slot_stats [Buckets * Ways];
   rsp_type     expected_results [$];

   function automatic int find_slot(logic [31:0] key);
      int base;
      base = int'(key % Buckets) * Ways;
      for (int w = 0; w < Ways; w++)
         if (slot_used[base + w] && slot_stats[base + w].key == key) return base + w;
      return -1;
   endfunction

   function automatic int claim_slot(logic [31:0] key);
      int base;
      base = int'(key % Buckets) * Ways;
      for (int w = 0; w < Ways; w++)
         if (!slot_used[base + w]) begin
            slot_used[base + w] = 1'b1;
            slot_stats[base + w] = '{valid: 1'b1, key: key, calls: 0, tmin: Sat32,
                                     tmax: 0, total: 0};
            return base + w;
         end
      return -1;
   endfunction

   function automatic rsp_type profile_event(req_type t);
      rsp_type r;
      int s;
      logic [63:0] diff;
      logic [32:0] sum;
      logic [31:0] dur;
      r = '0;
      r.event_kind = t.opcode;
      if (t.opcode == OP_ENTER) begin
         r.resume_addr = t.return_addr;
         r.func_addr = t.call_site - CallLen;
         if (!prof_enable) begin
            r.status = ST_DISABLED;
            return r;
         end
         if (frame_depth >= StackDepth) begin
            r.status = ST_OVERFLOW;
            return r;
         end
         frame_func[frame_depth] = r.func_addr;
         frame_ret[frame_depth] = t.return_addr;
         frame_time[frame_depth] = t.timestamp;
         frame_depth++;
         r.redirect = 1'b1;
         s = find_slot(r.func_addr);
         if (s < 0) s = claim_slot(r.func_addr);
         if (s < 0) begin
            r.status = ST_FULL;
            return r;
         end
         if (slot_stats[s].calls != Sat32) slot_stats[s].calls++;
      end else begin
         if (frame_depth == 0) begin
            r.status = ST_UNDERFLOW;
            return r;
         end
         frame_depth--;
         r.resume_addr = frame_ret[frame_depth];
         r.func_addr = frame_func[frame_depth];
         diff = t.timestamp - frame_time[frame_depth];
         dur = (diff > 64'(Sat32)) ? Sat32 : diff[31:0];
         r.duration = dur;
         s = find_slot(r.func_addr);
         if (s < 0) begin
            r.status = ST_UNTRACKED;
            return r;
         end
         if (slot_stats[s].tmin > dur) slot_stats[s].tmin = dur;
         if (slot_stats[s].tmax < dur) slot_stats[s].tmax = dur;
         sum = {1'b0, slot_stats[s].total} + {1'b0, dur};
         slot_stats[s].total = sum[32] ? Sat32 : sum[31:0];
      end
      r.call_count = slot_stats[s].calls;
      r.time_min = slot_stats[s].tmin;
      r.time_max = slot_stats[s].tmax;
      r.time_total = slot_stats[s].total;
      r.status = ST_OK;
      return r;
   endfunction

   // predict on accepted requests, compare accepted results
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         prof_enable <= 1'b0;
         frame_depth = 0;
         for (int i = 0; i < Buckets * Ways; i++) slot_used[i] = 1'b0;
         expected_results.delete();
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (csr_wr_en) prof_enable <= csr_wr_data;
         if (req_valid && !req_stall) expected_results.push_back(profile_event(req_data));
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected result %p", rsp_data);
            end else begin
               want = expected_results.pop_front();
               if (want !== rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

[bench/tb_call_stack_profiler.sv]
`timescale 1ns / 1ps
module tb_call_stack_profiler;
   import csp_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic    csr_wr_data = 1'b0;
   int      fail_count, pending_count, result_count;
   int      send_idle_pct = 0, recv_idle_pct = 0, hold_cycles = 0;
   int      item_count = 0;
   logic [31:0] live_sites [$];
   logic [63:0] now_stamp = 64'd1000;

   call_stack_profiler dut (.*);

   call_stack_profiler_checker checker_i (.*);

   initial forever #1 clock = ~clock;

   // receiver: random stall, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // valid stays high after acceptance until the next event or a drain drops it
   task automatic send_event(logic op, logic [31:0] site, logic [31:0] ret, logic [63:0] ts);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{opcode: op, call_site: site, return_addr: ret, timestamp: ts};
      do @(posedge clock); while (req_stall);
      item_count++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_enable(logic value);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // mostly an enter with a random or small-pool site, or an exit that pops a live site
   task automatic random_event();
      logic [31:0] site;
      now_stamp += $urandom_range(1, 3) == 1 ? {$urandom, $urandom} : 64'($urandom_range(500));
      if (live_sites.size() != 0 && $urandom_range(1)) begin
         void'(live_sites.pop_back());
         send_event(OP_EXIT, $urandom, $urandom, now_stamp);
      end else begin
         case ($urandom_range(3))
            0: site = $urandom;
            1: site = 32'($urandom_range(40)) * 256 + 37;
            default: site = 32'($urandom_range(60)) + 5;
         endcase
         if (live_sites.size() < 300) live_sites.push_back(site);
         send_event($urandom_range(19) == 0, site, $urandom, now_stamp);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: disabled enter, underflow, then enabled extremes
      send_event(OP_ENTER, 32'h0, 32'hffffffff, 64'h0);
      send_event(OP_EXIT, 32'h0, 32'h0, 64'hffffffffffffffff);
      write_enable(1'b1);
      send_event(OP_ENTER, 32'hffffffff, 32'h0, 64'hffffffffffffff00);
      send_event(OP_EXIT, 32'h0, 32'h0, 64'h10);
      send_event(OP_ENTER, 32'h0, 32'h12345678, 64'h0);
      send_event(OP_EXIT, 32'h0, 32'h0, 64'hffffffffffffffff);
      send_event(OP_ENTER, 32'h0, 32'h1, 64'h0);
      send_event(OP_EXIT, 32'h0, 32'h0, 64'h0000000200000000);
      // fill one bucket, then bucket full and untracked exit
      for (int i = 0; i < 5; i++)
         send_event(OP_ENTER, 32'(i * 256 + 7), 32'(i), 64'(i));
      for (int i = 0; i < 5; i++)
         send_event(OP_EXIT, 32'h0, 32'h0, 64'd100 + 64'(i));
      // overflow the stack, then unwind fully
      for (int i = 0; i < 257; i++) send_event(OP_ENTER, 32'd9, 32'(i), 64'(i));
      for (int i = 0; i < 256; i++) send_event(OP_EXIT, 32'h0, 32'h0, 64'd300 + 64'(i));
      drain_results();
      write_enable(1'b0);
      send_event(OP_ENTER, 32'h5, 32'h5, 64'h5);
      write_enable(1'b1);

      // random phases with differing idle rates
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 49 : 0;
         recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 21 : 0;
         if (phase == 1) hold_cycles = 200;
         for (int i = 0; i < 140; i++) random_event();
         if (phase == 0) begin
            drain_results();
            write_enable(1'b0);
            for (int i = 0; i < 20; i++) random_event();
            write_enable(1'b1);
         end
      end
      drain_results();
      $display("covered %0d transactions, %0d results: enter/exit, disabled, overflow,",
               item_count, result_count);
      $display("underflow, bucket full, untracked and saturation under random stalls");
      if (fail_count == 0) $display("call_stack_profiler test passed");
      else $display("call_stack_profiler test failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("call_stack_profiler test failed");
      $finish;
   end

endmodule
